### rtl/rasmt_pkg.sv
`timescale 1ns / 1ps
package rasmt_pkg;

    localparam int LEAVES      = 1024;
    localparam int POS_W       = 10;
    localparam int CNT_W       = POS_W + 1;
    localparam int NODES       = 4 * LEAVES;
    localparam int NODE_AW     = $clog2(NODES);
    localparam int STACK_DEPTH = 32;
    localparam int STACK_AW    = $clog2(STACK_DEPTH);
    localparam int SP_W        = STACK_AW + 1;
    localparam int IDX_W       = 2;

    localparam logic signed [31:0] EMPTY_MAX = 32'sh88CA6C00;

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [IDX_W-1:0] REG_SPAN_LOW  = 2'd0;
    localparam logic [IDX_W-1:0] REG_SPAN_HIGH = 2'd1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_POP,
        S_LEAF_RD,
        S_LEAF_DO,
        S_PD_RK,
        S_PD_RL,
        S_PD_MUL,
        S_PD_WL,
        S_PD_WR,
        S_PD_WK,
        S_PU_RL,
        S_PU_RR,
        S_PU_WK,
        S_DONE
    } seq_state_t;

    typedef struct packed {
        logic [63:0]        sm;
        logic signed [31:0] mx;
        logic signed [31:0] pend;
    } node_t;

    typedef struct packed {
        logic [NODE_AW-1:0] k;
        logic [POS_W-1:0]   lo;
        logic [POS_W-1:0]   hi;
        logic               pull;
    } frame_t;

    typedef struct packed {
        logic               op;
        logic [POS_W-1:0]   u;
        logic [POS_W-1:0]   v;
        logic signed [31:0] d;
        logic [POS_W-1:0]   lo;
        logic [POS_W-1:0]   hi;
        logic               span_ok;
    } cmd_t;

    typedef struct packed {
        logic signed [31:0] mx;
        logic [63:0]        sm;
        logic               empty;
    } res_t;

endpackage

### rtl/rasmt_mem.sv
`timescale 1ns / 1ps
module rasmt_mem #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 4096,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/rasmt_seq.sv
`timescale 1ns / 1ps
module rasmt_seq (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            clear_start,
    input  logic            cmd_valid,
    input  rasmt_pkg::cmd_t cmd,
    output logic            cmd_ready,
    output logic            res_valid,
    output rasmt_pkg::res_t res,
    input  logic            res_ready
);
    import rasmt_pkg::*;

    // signed delta times unsigned count, sign-extended to 64 bits
    function automatic logic [63:0] mul_cnt(input logic signed [31:0] a,
                                            input logic [CNT_W-1:0] c);
        logic signed [CNT_W+32:0] p;
        p = a * $signed({1'b0, c});
        return {{(64 - CNT_W - 33){p[CNT_W+32]}}, p};
    endfunction

    seq_state_t state_reg, state_next;
    logic [SP_W-1:0] sp_reg, sp_next;
    logic [NODE_AW-1:0] clr_reg, clr_next;
    frame_t stack_reg [STACK_DEPTH];
    frame_t cur_reg, cur_next;
    cmd_t cmd_reg, cmd_next;
    node_t kn_reg, kn_next;
    node_t ch_reg, ch_next;
    logic [63:0] prod_reg, prod_next;
    logic [63:0] prodl_reg, prodl_next;
    logic [63:0] prodr_reg, prodr_next;
    logic hit_reg, hit_next;
    logic signed [31:0] amax_reg, amax_next;
    logic [63:0] asum_reg, asum_next;

    logic we, re;
    logic [NODE_AW-1:0] waddr, raddr;
    node_t wdata, rdata;

    logic [1:0] push_num;
    frame_t pf0, pf1, pf2;
    frame_t top_fr;
    logic [SP_W-1:0] sp_m1, sp_p1, sp_p2;

    logic [POS_W-1:0] mid;
    logic [POS_W:0] mid_sum;
    logic [CNT_W-1:0] cnt_all, cnt_l, cnt_r;
    logic [NODE_AW-1:0] kl, kr;
    logic pop_disj, pop_cov;

    rasmt_mem #(
        .WIDTH ($bits(node_t)),
        .DEPTH (NODES)
    ) u_mem (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign sp_m1  = sp_reg - SP_W'(1);
    assign sp_p1  = sp_reg + SP_W'(1);
    assign sp_p2  = sp_reg + SP_W'(2);
    assign top_fr = stack_reg[sp_m1[STACK_AW-1:0]];

    assign mid_sum = {1'b0, cur_reg.lo} + {1'b0, cur_reg.hi};
    assign mid     = mid_sum[POS_W:1];
    assign cnt_l   = {1'b0, mid} - {1'b0, cur_reg.lo} + CNT_W'(1);
    assign cnt_r   = {1'b0, cur_reg.hi} - {1'b0, mid};
    assign cnt_all = {1'b0, top_fr.hi} - {1'b0, top_fr.lo} + CNT_W'(1);
    assign kl      = {cur_reg.k[NODE_AW-2:0], 1'b0};
    assign kr      = {cur_reg.k[NODE_AW-2:0], 1'b1};

    assign pop_disj = (cmd_reg.v < top_fr.lo) || (top_fr.hi < cmd_reg.u);
    assign pop_cov  = (cmd_reg.u <= top_fr.lo) && (top_fr.hi <= cmd_reg.v);

    always_comb
    begin
        res.mx    = hit_reg ? amax_reg : EMPTY_MAX;
        res.sm    = hit_reg ? asum_reg : 64'd0;
        res.empty = !hit_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        sp_next    = sp_reg;
        clr_next   = clr_reg;
        cur_next   = cur_reg;
        cmd_next   = cmd_reg;
        kn_next    = kn_reg;
        ch_next    = ch_reg;
        prod_next  = prod_reg;
        prodl_next = prodl_reg;
        prodr_next = prodr_reg;
        hit_next   = hit_reg;
        amax_next  = amax_reg;
        asum_next  = asum_reg;
        we         = 1'b0;
        re         = 1'b0;
        waddr      = cur_reg.k;
        raddr      = cur_reg.k;
        wdata      = '0;
        push_num   = 2'd0;
        pf0        = '0;
        pf1        = '0;
        pf2        = '0;
        cmd_ready  = 1'b0;
        res_valid  = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                // no transfer in the cycle that starts a clearing pass
                cmd_ready = !clear_start;
                if (cmd_valid)
                begin
                    cmd_next  = cmd;
                    hit_next  = 1'b0;
                    amax_next = '0;
                    asum_next = '0;
                    if (cmd.span_ok)
                    begin
                        push_num   = 2'd1;
                        pf0        = '{k: NODE_AW'(1), lo: cmd.lo, hi: cmd.hi, pull: 1'b0};
                        state_next = S_POP;
                    end
                    else if (cmd.op == OP_QUERY)
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_CLEAR:
            begin
                we       = 1'b1;
                waddr    = clr_reg;
                wdata    = '0;
                clr_next = clr_reg + NODE_AW'(1);
                if (&clr_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            S_POP:
            begin
                if (sp_reg == '0)
                begin
                    state_next = (cmd_reg.op == OP_QUERY) ? S_DONE : S_IDLE;
                end
                else
                begin
                    sp_next  = sp_m1;
                    cur_next = top_fr;
                    if (top_fr.pull)
                    begin
                        state_next = S_PU_RL;
                    end
                    else if (pop_disj)
                    begin
                        state_next = S_POP;
                    end
                    else if (pop_cov)
                    begin
                        prod_next  = mul_cnt(cmd_reg.d, cnt_all);
                        state_next = S_LEAF_RD;
                    end
                    else
                    begin
                        state_next = S_PD_RK;
                    end
                end
            end
            S_LEAF_RD:
            begin
                re         = 1'b1;
                state_next = S_LEAF_DO;
            end
            S_LEAF_DO:
            begin
                if (cmd_reg.op == OP_ADD)
                begin
                    we         = 1'b1;
                    wdata.sm   = rdata.sm + prod_reg;
                    wdata.mx   = rdata.mx + cmd_reg.d;
                    wdata.pend = rdata.pend + cmd_reg.d;
                end
                else
                begin
                    hit_next  = 1'b1;
                    asum_next = asum_reg + rdata.sm;
                    if (!hit_reg || (amax_reg < rdata.mx))
                    begin
                        amax_next = rdata.mx;
                    end
                end
                state_next = S_POP;
            end
            S_PD_RK:
            begin
                re         = 1'b1;
                state_next = S_PD_RL;
            end
            S_PD_RL:
            begin
                kn_next    = rdata;
                re         = 1'b1;
                raddr      = kl;
                state_next = S_PD_MUL;
            end
            S_PD_MUL:
            begin
                prodl_next = mul_cnt(kn_reg.pend, cnt_l);
                prodr_next = mul_cnt(kn_reg.pend, cnt_r);
                state_next = S_PD_WL;
            end
            S_PD_WL:
            begin
                we         = 1'b1;
                waddr      = kl;
                wdata.sm   = rdata.sm + prodl_reg;
                wdata.mx   = rdata.mx + kn_reg.pend;
                wdata.pend = rdata.pend + kn_reg.pend;
                re         = 1'b1;
                raddr      = kr;
                state_next = S_PD_WR;
            end
            S_PD_WR:
            begin
                we         = 1'b1;
                waddr      = kr;
                wdata.sm   = rdata.sm + prodr_reg;
                wdata.mx   = rdata.mx + kn_reg.pend;
                wdata.pend = rdata.pend + kn_reg.pend;
                state_next = S_PD_WK;
            end
            S_PD_WK:
            begin
                we         = 1'b1;
                wdata.sm   = kn_reg.sm;
                wdata.mx   = kn_reg.mx;
                wdata.pend = '0;
                // left child ends on top so it is visited first
                if (cmd_reg.op == OP_ADD)
                begin
                    push_num = 2'd3;
                    pf0 = '{k: cur_reg.k, lo: cur_reg.lo, hi: cur_reg.hi, pull: 1'b1};
                    pf1 = '{k: kr, lo: mid + POS_W'(1), hi: cur_reg.hi, pull: 1'b0};
                    pf2 = '{k: kl, lo: cur_reg.lo, hi: mid, pull: 1'b0};
                end
                else
                begin
                    push_num = 2'd2;
                    pf0 = '{k: kr, lo: mid + POS_W'(1), hi: cur_reg.hi, pull: 1'b0};
                    pf1 = '{k: kl, lo: cur_reg.lo, hi: mid, pull: 1'b0};
                end
                state_next = S_POP;
            end
            S_PU_RL:
            begin
                re         = 1'b1;
                raddr      = kl;
                state_next = S_PU_RR;
            end
            S_PU_RR:
            begin
                ch_next    = rdata;
                re         = 1'b1;
                raddr      = kr;
                state_next = S_PU_WK;
            end
            S_PU_WK:
            begin
                we         = 1'b1;
                wdata.sm   = ch_reg.sm + rdata.sm;
                wdata.mx   = (ch_reg.mx < rdata.mx) ? rdata.mx : ch_reg.mx;
                wdata.pend = '0;
                state_next = S_POP;
            end
            S_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (push_num != 2'd0)
        begin
            sp_next = sp_reg + SP_W'(push_num);
        end

        // a span write wipes the tree, whatever was going on
        if (clear_start)
        begin
            state_next = S_CLEAR;
            clr_next   = '0;
            sp_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            sp_reg    <= '0;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sp_reg    <= sp_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        cmd_reg   <= cmd_next;
        kn_reg    <= kn_next;
        ch_reg    <= ch_next;
        prod_reg  <= prod_next;
        prodl_reg <= prodl_next;
        prodr_reg <= prodr_next;
        hit_reg   <= hit_next;
        amax_reg  <= amax_next;
        asum_reg  <= asum_next;
        if (push_num != 2'd0)
        begin
            stack_reg[sp_reg[STACK_AW-1:0]] <= pf0;
        end
        if (push_num >= 2'd2)
        begin
            stack_reg[sp_p1[STACK_AW-1:0]] <= pf1;
        end
        if (push_num == 2'd3)
        begin
            stack_reg[sp_p2[STACK_AW-1:0]] <= pf2;
        end
    end

endmodule

### rtl/range_add_sum_max_tree_top.sv
`timescale 1ns / 1ps
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_ready    op, range_first, range_last, delta
// out      output     out_valid / out_ready  range_max, range_sum, empty_res
// cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item at a time. Each node on the walk is skipped, read and updated when fully
// covered, or split (pushing its pending delta to both children, plus a pull-up of
// the children when adding); a query ends with the result. A range splits at most
// about 20 nodes and meets about 20 others.
// The pace is set by the single read and single write port of the node memory.
// After reset, and after each span write, a clearing pass zeroes the node memory; no
// input transfer is taken meanwhile (cfg transfers always are).
// A finished result sits in the output register; the next item is taken while it waits.
module range_add_sum_max_tree_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         op,
    input  logic [rasmt_pkg::POS_W-1:0]  range_first,
    input  logic [rasmt_pkg::POS_W-1:0]  range_last,
    input  logic signed [31:0]           delta,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [31:0]           range_max,
    output logic signed [63:0]           range_sum,
    output logic                         empty_res,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [rasmt_pkg::IDX_W-1:0]  cfg_index,
    input  logic [rasmt_pkg::POS_W-1:0]  cfg_data
);
    import rasmt_pkg::*;

    logic [POS_W-1:0] span_low_reg, span_high_reg;
    logic out_valid_reg;
    res_t out_reg;

    cmd_t cmd;
    res_t res;
    logic res_valid, res_ready;
    logic cfg_hit;

    // any transfer to a span register restarts the clearing pass
    assign cfg_ready = 1'b1;
    assign cfg_hit   = cfg_valid && ((cfg_index == REG_SPAN_LOW) ||
                                     (cfg_index == REG_SPAN_HIGH));

    // the span is at most 1024 wide with 10-bit registers, so no clamp is needed
    always_comb
    begin
        cmd.op      = op;
        cmd.u       = range_first;
        cmd.v       = range_last;
        cmd.d       = delta;
        cmd.lo      = span_low_reg;
        cmd.hi      = span_high_reg;
        cmd.span_ok = (span_low_reg <= span_high_reg);
    end

    rasmt_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .clear_start (cfg_hit),
        .cmd_valid   (in_valid),
        .cmd         (cmd),
        .cmd_ready   (in_ready),
        .res_valid   (res_valid),
        .res         (res),
        .res_ready   (res_ready)
    );

    // output register frees the sequencer while the result waits
    assign res_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            span_low_reg  <= '0;
            span_high_reg <= '1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && (cfg_index == REG_SPAN_LOW))
            begin
                span_low_reg <= cfg_data;
            end
            if (cfg_valid && (cfg_index == REG_SPAN_HIGH))
            begin
                span_high_reg <= cfg_data;
            end
            if (res_ready)
            begin
                out_valid_reg <= res_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign range_max = out_reg.mx;
    assign range_sum = out_reg.sm;
    assign empty_res = out_reg.empty;

endmodule

### tb/range_add_sum_max_tree_top_tb.sv
`timescale 1ns / 1ps
module range_add_sum_max_tree_top_tb;
    import rasmt_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 3000000;
    localparam int          DRAIN_CYCLES = 400;   // margin for the last walk to finish

    typedef struct {
        logic               op;
        logic [POS_W-1:0]   first;
        logic [POS_W-1:0]   last;
        logic signed [31:0] delta;
    } job_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic                op;
    logic [POS_W-1:0]    range_first;
    logic [POS_W-1:0]    range_last;
    logic signed [31:0]  delta;
    logic                out_valid;
    logic                out_ready;
    logic signed [31:0]  range_max;
    logic signed [63:0]  range_sum;
    logic                empty_res;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [IDX_W-1:0]    cfg_index;
    logic [POS_W-1:0]    cfg_data;

    range_add_sum_max_tree_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .range_first (range_first),
        .range_last  (range_last),
        .delta       (delta),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .range_max   (range_max),
        .range_sum   (range_sum),
        .empty_res   (empty_res),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // Shadow tree: lazy segment tree over [span_lo, span_hi], node k has
    // children 2k and 2k+1, split at (lo + hi) >> 1.
    // ------------------------------------------------------------------
    logic [63:0]  seg_sum  [NODES];
    logic [31:0]  seg_peak [NODES];
    logic [31:0]  seg_tag  [NODES];
    logic [POS_W-1:0] span_lo;
    logic [POS_W-1:0] span_hi;

    // query accumulators
    logic         probe_hit;
    logic [31:0]  probe_peak;
    logic [63:0]  probe_sum;

    job_t   pending_jobs[$];
    res_t   expected_res[$];
    int     errors;
    bit     in_taken;
    int     gap_left;
    int     burst_left;

    function automatic void wipe_tree();
        for (int i = 0; i < NODES; i++)
        begin
            seg_sum[i]  = '0;
            seg_peak[i] = '0;
            seg_tag[i]  = '0;
        end
    endfunction

    function automatic void tag_node(int unsigned k, int unsigned cnt, logic [31:0] d);
        if (k >= NODES)
            return;
        seg_sum[k]  = seg_sum[k] + {{32{d[31]}}, d} * 64'(cnt);
        seg_peak[k] = seg_peak[k] + d;
        seg_tag[k]  = seg_tag[k] + d;
    endfunction

    function automatic void spread_tag(int unsigned k, int unsigned lo, int unsigned hi);
        int unsigned mid;
        if (lo == hi || k >= NODES)
            return;
        mid = (lo + hi) >> 1;
        tag_node(2 * k, mid - lo + 1, seg_tag[k]);
        tag_node(2 * k + 1, hi - mid, seg_tag[k]);
        seg_tag[k] = '0;
    endfunction

    function automatic void range_add(int unsigned k, int unsigned lo, int unsigned hi,
                                      int unsigned u, int unsigned v, logic [31:0] d);
        int unsigned mid;
        if (k >= NODES || v < lo || hi < u)
            return;
        if (u <= lo && hi <= v)
        begin
            tag_node(k, hi - lo + 1, d);
            return;
        end
        spread_tag(k, lo, hi);
        mid = (lo + hi) >> 1;
        range_add(2 * k, lo, mid, u, v, d);
        range_add(2 * k + 1, mid + 1, hi, u, v, d);
        if (2 * k + 1 < NODES)
        begin
            seg_peak[k] = ($signed(seg_peak[2*k]) < $signed(seg_peak[2*k+1]))
                          ? seg_peak[2*k+1] : seg_peak[2*k];
            seg_sum[k]  = seg_sum[2*k] + seg_sum[2*k+1];
        end
    endfunction

    function automatic void range_probe(int unsigned k, int unsigned lo, int unsigned hi,
                                        int unsigned u, int unsigned v);
        int unsigned mid;
        if (k >= NODES || v < lo || hi < u)
            return;
        if (u <= lo && hi <= v)
        begin
            if (!probe_hit || $signed(probe_peak) < $signed(seg_peak[k]))
                probe_peak = seg_peak[k];
            probe_hit = 1'b1;
            probe_sum = probe_sum + seg_sum[k];
            return;
        end
        spread_tag(k, lo, hi);
        mid = (lo + hi) >> 1;
        range_probe(2 * k, lo, mid, u, v);
        range_probe(2 * k + 1, mid + 1, hi, u, v);
    endfunction

    // Apply one accepted item; queue its result for queries.
    function automatic void predict_item(job_t j);
        int unsigned lo;
        int unsigned hi;
        bit          span_ok;
        res_t        r;
        lo = span_lo;
        hi = span_hi;
        span_ok = (lo <= hi);
        if (span_ok && hi - lo + 1 > LEAVES)
            hi = lo + LEAVES - 1;
        if (j.op == OP_ADD)
        begin
            if (span_ok)
                range_add(1, lo, hi, j.first, j.last, j.delta);
            return;
        end
        probe_hit  = 1'b0;
        probe_peak = '0;
        probe_sum  = '0;
        if (span_ok)
            range_probe(1, lo, hi, j.first, j.last);
        if (probe_hit)
        begin
            r.mx    = probe_peak;
            r.sm    = probe_sum;
            r.empty = 1'b0;
        end
        else
        begin
            r.mx    = EMPTY_MAX;
            r.sm    = '0;
            r.empty = 1'b1;
        end
        expected_res.push_back(r);
    endfunction

    // ------------------------------------------------------------------
    // Input driver: bursts of random length separated by random gaps.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        job_t j;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!(in_valid && !in_taken))
        begin
            if (gap_left > 0)
            begin
                gap_left = gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (pending_jobs.size() > 0)
            begin
                j = pending_jobs.pop_front();
                op          <= j.op;
                range_first <= j.first;
                range_last  <= j.last;
                delta       <= j.delta;
                in_valid    <= 1'b1;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 16);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
                else
                begin
                    burst_left = burst_left - 1;
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
        in_taken = 1'b0;
    end

    // Input transfer: predict from the sampled payload.
    always @(posedge clk)
    begin
        job_t j;
        if (rst_n && in_valid && in_ready)
        begin
            j.op    = op;
            j.first = range_first;
            j.last  = range_last;
            j.delta = delta;
            predict_item(j);
            in_taken = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: alternates between always-ready and random stalls, and
    // once holds off for a long stretch so the block backs up its input.
    // ------------------------------------------------------------------
    int rx_cycle;
    int rx_mode_left;
    int rx_mode;

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_ready    <= 1'b0;
            rx_cycle     = 0;
            rx_mode_left = 0;
            rx_mode      = 0;
        end
        else
        begin
            rx_cycle = rx_cycle + 1;
            if (rx_mode_left == 0)
            begin
                rx_mode      = $urandom_range(0, 2);
                rx_mode_left = $urandom_range(16, 200);
            end
            rx_mode_left = rx_mode_left - 1;
            if (rx_cycle >= 40000 && rx_cycle < 43000)
                out_ready <= 1'b0;
            else if (rx_mode == 0)
                out_ready <= 1'b1;
            else if (rx_mode == 1)
                out_ready <= ($urandom_range(0, 3) != 0);
            else
                out_ready <= ($urandom_range(0, 4) == 0);
        end
    end

    // Output monitor
    always @(posedge clk)
    begin
        res_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_res.size() == 0)
            begin
                $display("%0t: unexpected result max=%0d sum=%0d empty=%0b",
                         $time, range_max, range_sum, empty_res);
                errors++;
            end
            else
            begin
                e = expected_res.pop_front();
                if (range_max !== e.mx)
                begin
                    $display("%0t: range_max expected %0d actual %0d", $time, e.mx, range_max);
                    errors++;
                end
                if (range_sum !== e.sm)
                begin
                    $display("%0t: range_sum expected %0d actual %0d",
                             $time, $signed(e.sm), range_sum);
                    errors++;
                end
                if (empty_res !== e.empty)
                begin
                    $display("%0t: empty_res expected %0b actual %0b", $time, e.empty, empty_res);
                    errors++;
                end
            end
        end
    end

    // Watchdog
    int unsigned cycle_count;
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("range_add_sum_max_tree_top_tb: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void queue_job(logic o, int unsigned f, int unsigned l, logic [31:0] d);
        job_t j;
        j.op    = o;
        j.first = f[POS_W-1:0];
        j.last  = l[POS_W-1:0];
        j.delta = d;
        pending_jobs.push_back(j);
    endfunction

    function automatic logic [31:0] pick_delta();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel <= 5)
            return 32'($signed($urandom_range(0, 2000)) - 1000);
        else if (sel == 6)
            return $urandom;
        else if (sel == 7)
            return ($urandom_range(0, 1) == 0) ? 32'h7FFFFFFF : 32'h80000000;
        return 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
    endfunction

    // Mostly ranges inside the span; some short, inverted, wide or outside ones.
    task automatic queue_random(int count);
        int unsigned a;
        int unsigned b;
        int unsigned t;
        int          sel;
        for (int n = 0; n < count; n++)
        begin
            sel = $urandom_range(0, 9);
            if (sel <= 5)
            begin
                a = $urandom_range(span_lo, span_hi);
                b = $urandom_range(span_lo, span_hi);
                if (a > b)
                begin
                    t = a;
                    a = b;
                    b = t;
                end
            end
            else if (sel == 6)
            begin
                a = $urandom_range(0, 1020);
                b = a + $urandom_range(0, 3);
            end
            else if (sel == 7)
            begin
                a = $urandom_range(0, 1023);
                b = $urandom_range(0, 1023);
            end
            else if (sel == 8)
            begin
                a = $urandom_range(0, span_lo);
                b = $urandom_range(span_hi, 1023);
            end
            else
            begin
                a = $urandom_range(0, 1023);
                b = a;
            end
            queue_job($urandom_range(0, 1), a, b, pick_delta());
        end
    endtask

    task automatic wait_idle();
        while (pending_jobs.size() != 0 || in_valid || expected_res.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Register write; span writes clear the shadow tree, other indexes are no-ops.
    task automatic write_reg(logic [IDX_W-1:0] idx, logic [POS_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == REG_SPAN_LOW)
        begin
            span_lo = val;
            wipe_tree();
        end
        else if (idx == REG_SPAN_HIGH)
        begin
            span_hi = val;
            wipe_tree();
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_span(int unsigned lo, int unsigned hi, int count);
        wait_idle();
        write_reg(REG_SPAN_LOW, lo[POS_W-1:0]);
        write_reg(REG_SPAN_HIGH, hi[POS_W-1:0]);
        queue_random(count);
    endtask

    initial
    begin
        errors      = 0;
        in_taken    = 1'b0;
        gap_left    = 0;
        burst_left  = 0;
        cycle_count = 0;
        span_lo     = '0;
        span_hi     = 10'd1023;
        wipe_tree();
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        op          = OP_ADD;
        range_first = '0;
        range_last  = '0;
        delta       = '0;
        out_ready   = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: extremes, wrap, inverted and partial ranges, on reset span.
        queue_job(OP_QUERY, 0, 1023, 0);
        queue_job(OP_ADD, 0, 1023, 1);
        queue_job(OP_QUERY, 0, 0, 0);
        queue_job(OP_QUERY, 1023, 1023, 0);
        queue_job(OP_ADD, 0, 1023, 32'h7FFFFFFF);
        queue_job(OP_QUERY, 0, 1023, 0);
        queue_job(OP_ADD, 512, 1023, 32'h80000000);
        queue_job(OP_QUERY, 0, 1023, 0);
        queue_job(OP_QUERY, 500, 600, 0);
        queue_job(OP_ADD, 700, 300, 32'h12345678);
        queue_job(OP_QUERY, 700, 300, 0);
        queue_job(OP_ADD, 5, 5, 32'hFFFFFFFF);
        queue_job(OP_QUERY, 4, 6, 0);
        queue_job(OP_ADD, 0, 1023, 32'h80000000);
        queue_job(OP_QUERY, 0, 1023, 0);
        queue_job(OP_QUERY, 341, 682, 32'hFFFFFFFF);
        queue_job(OP_ADD, 1, 1022, 32'h55555555);
        queue_job(OP_QUERY, 0, 1, 0);
        queue_job(OP_QUERY, 1022, 1023, 0);
        queue_random(60);

        // Writes to unused indexes must leave the tree alone.
        wait_idle();
        write_reg(2'd2, 10'h3FF);
        write_reg(2'd3, 10'h155);
        queue_random(90);

        run_span(100, 355, 110);
        run_span(5, 5, 60);
        run_span(1023, 1023, 60);
        run_span(600, 200, 50);      // inverted span: everything empty
        run_span(0, 0, 60);
        run_span(0, 1023, 160);
        run_span(512, 1023, 120);
        run_span(0, 511, 120);
        run_span(0, 1, 60);
        run_span(333, 334, 60);
        run_span(1, 1022, 150);
        run_span(0, 1023, 110);

        wait_idle();
        if (errors == 0)
            $display("range_add_sum_max_tree_top_tb: clean");
        else
            $display("range_add_sum_max_tree_top_tb: errors");
        $finish;
    end

endmodule
